[hw/rtl/fixed_slot_pool_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fixed slot pool allocator
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define FSPA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the cycle after its trigger
`define FSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fspa_pkg.sv]
// ----------------------------------------------------------------------------
// fspa_pkg
// Types, sizes and codes shared by the fixed slot pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fspa_pkg;

  // Pool geometry
  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
  localparam int COUNT_W    = SLOT_IDX_W + 1;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int SCOUNT_W   = 9;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Release search: slots compared per cycle
  localparam int LANES      = 16;
  localparam int LANE_W     = $clog2(LANES);
  localparam int CHUNKS     = MAX_SLOTS / LANES;
  localparam int CHUNK_W    = SLOT_IDX_W - LANE_W;
  localparam int LANE_OFF_W = SIZE_W + LANE_W + 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd2;

  // Register reset values
  localparam logic [ADDR_W-1:0]   RST_BASE_ADDRESS = '0;
  localparam logic [SIZE_W-1:0]   RST_SLOT_SIZE    = 17'd64;
  localparam logic [SCOUNT_W-1:0] RST_SLOT_COUNT   = 9'd256;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;

  // Command classes produced by the front end
  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_REL_NULL,
    KIND_REL_SEARCH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  // Number of slots the pool holds for a given slot count register
  function automatic logic [COUNT_W-1:0] pool_slots(input logic [SCOUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] lim;
    lim = COUNT_W'(MAX_SLOTS);
    if (COUNT_W'(cnt) > lim) begin
      return lim;
    end
    return COUNT_W'(cnt);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fspa_if.sv]
// ----------------------------------------------------------------------------
// fspa_if
// Request and response channels of the fixed slot pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface fspa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [fspa_pkg::ADDR_W-1:0] release_address;

  modport source (output valid, output operation, output release_address, input ready);
  modport sink   (input valid, input operation, input release_address, output ready);
endinterface

interface fspa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fspa_pkg::ADDR_W-1:0]   slot_address;
  logic [fspa_pkg::STATUS_W-1:0] status;

  modport source (output valid, output slot_address, output status, input ready);
  modport sink   (input valid, input slot_address, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/fspa_front.sv]
// ----------------------------------------------------------------------------
// fspa_front
// Accepts request transactions, classifies them and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  fspa_req_if.sink            req_i,
  output fspa_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_pop_i
);
  import fspa_pkg::*;

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;
  cmd_t              cmd_new;

  // Classify the incoming request
  always_comb begin
    cmd_new.addr = req_i.release_address;
    if (req_i.operation == OP_ALLOC) begin
      cmd_new.kind = KIND_ALLOC;
    end else if (req_i.release_address == '0) begin
      cmd_new.kind = KIND_REL_NULL;
    end else begin
      cmd_new.kind = KIND_REL_SEARCH;
    end
  end

  assign req_i.ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push         = req_i.valid && req_i.ready;
  assign cmd_valid_o  = (count_q != '0);
  assign pop          = cmd_pop_i && cmd_valid_o;
  assign cmd_o        = queue_q[rd_ptr_q];

  // Store queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fspa_back.sv]
// ----------------------------------------------------------------------------
// fspa_back
// Executes queued commands against the free stack and in-use flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_slot_pool_allocator_assert.svh"

module fspa_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fspa_pkg::cmd_t                  cmd_i,
  input  wire logic                            cmd_valid_i,
  output logic                                 cmd_pop_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fspa_rsp_if.source                           rsp_o
);
  import fspa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ALLOC  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  // Configuration
  logic [ADDR_W-1:0]   base_q;
  logic [SIZE_W-1:0]   size_q;
  logic [SCOUNT_W-1:0] scount_q;
  logic [SCOUNT_W-1:0] scount_next;
  logic [COUNT_W-1:0]  pool_n, init_n;
  logic                cfg_hit;

  // Pool state
  logic [SLOT_IDX_W-1:0] stack_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  written_q;
  logic [MAX_SLOTS-1:0]  in_use_q;
  logic [COUNT_W-1:0]    fc_q;

  // Sequencer
  logic [1:0]            state_q;
  logic [CHUNK_W-1:0]    ch_q;
  logic [ADDR_W-1:0]     addr_q, acc_q;
  logic [SLOT_IDX_W-1:0] rd_data_q, rd_init_q;
  logic                  rd_wr_q, empty_q;

  // Output register
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_free, out_load;

  // Datapath
  logic                  idle, quick, rd_en;
  logic [SLOT_IDX_W-1:0] rd_idx, alloc_idx, hit_slot;
  logic [LANE_W-1:0]     hit_lane;
  logic [LANES-1:0]      hits;
  logic [ADDR_W-1:0]     lane_addr [LANES];
  logic                  found, last_chunk, search_end, alloc_fin;
  logic [ADDR_W-1:0]     grant_addr;
  logic [SLOT_IDX_W+SIZE_W-1:0] grant_off;

  assign pool_n  = pool_slots(scount_q);
  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_BASE_ADDRESS ||
                                cfg_index_i == REG_SLOT_SIZE ||
                                cfg_index_i == REG_SLOT_COUNT);
  assign scount_next = (cfg_we_i && cfg_index_i == REG_SLOT_COUNT) ?
                       cfg_data_i[SCOUNT_W-1:0] : scount_q;
  assign init_n = pool_slots(scount_next);

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= RST_BASE_ADDRESS;
      size_q   <= RST_SLOT_SIZE;
      scount_q <= RST_SLOT_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BASE_ADDRESS: base_q   <= cfg_data_i[ADDR_W-1:0];
        REG_SLOT_SIZE:    size_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SLOT_COUNT:   scount_q <= cfg_data_i[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decide whether the head command can start
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign idle      = (state_q == S_IDLE);
  assign quick     = (cmd_i.kind != KIND_ALLOC) &&
                     (cmd_i.kind == KIND_REL_NULL || pool_n == '0);
  assign cmd_pop_o = idle && cmd_valid_i && (!quick || out_free);
  assign rd_en     = cmd_pop_o && (cmd_i.kind == KIND_ALLOC);
  assign rd_idx    = SLOT_IDX_W'(fc_q - 1'b1);

  // Slot popped off the stack: pushed entries, else the initial order
  assign alloc_idx  = rd_wr_q ? rd_data_q : rd_init_q;
  assign grant_off  = alloc_idx * size_q;
  assign grant_addr = base_q + ADDR_W'(grant_off);
  assign alloc_fin  = (state_q == S_ALLOC) && out_free;

  // Compare one chunk of slot addresses against the release address
  always_comb begin
    logic [SLOT_IDX_W-1:0] li;
    logic [LANE_OFF_W-1:0] off;
    hits     = '0;
    hit_lane = '0;
    for (int j = 0; j < LANES; j++) begin
      li  = {ch_q, LANE_W'(j)};
      off = LANE_OFF_W'(size_q) * LANE_OFF_W'(j);
      lane_addr[j] = acc_q + ADDR_W'(off);
      hits[j] = in_use_q[li] && (COUNT_W'(li) < pool_n) && (lane_addr[j] == addr_q);
    end
    for (int j = LANES - 1; j >= 0; j--) begin
      if (hits[j]) begin
        hit_lane = LANE_W'(j);
      end
    end
  end

  assign found      = |hits;
  assign hit_slot   = {ch_q, hit_lane};
  assign last_chunk = (ch_q == CHUNK_W'((pool_n - 1'b1) >> LANE_W));
  assign search_end = (state_q == S_SEARCH) && (found || last_chunk) && out_free;

  // Select the result to load
  always_comb begin
    out_load     = 1'b0;
    out_addr_d   = '0;
    out_status_d = ST_NOT_IN_USE;
    if (cmd_pop_o && quick) begin
      out_load = 1'b1;
    end else if (alloc_fin) begin
      out_load = 1'b1;
      if (empty_q) begin
        out_status_d = ST_EMPTY;
      end else begin
        out_addr_d   = grant_addr;
        out_status_d = ST_DONE;
      end
    end else if (search_end) begin
      out_load     = 1'b1;
      out_status_d = found ? ST_DONE : ST_NOT_IN_USE;
    end
  end

  // Free stack storage and registered read
  always_ff @(posedge clk_i) begin
    if (search_end && found) begin
      stack_mem[fc_q[SLOT_IDX_W-1:0]] <= hit_slot;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_idx];
    end
  end

  // Capture command operands
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_wr_q   <= written_q[rd_idx];
      rd_init_q <= SLOT_IDX_W'(pool_n - 1'b1 - COUNT_W'(rd_idx));
      empty_q   <= (fc_q == '0) || (fc_q > pool_n);
    end
    if (cmd_pop_o) begin
      addr_q <= cmd_i.addr;
    end
  end

  // Sequence commands and update pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_q      <= '0;
      acc_q     <= '0;
      fc_q      <= pool_slots(RST_SLOT_COUNT);
      in_use_q  <= '0;
      written_q <= '0;
    end else if (cfg_hit) begin
      state_q   <= S_IDLE;
      fc_q      <= init_n;
      in_use_q  <= '0;
      written_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o && !quick) begin
            ch_q    <= '0;
            acc_q   <= base_q;
            state_q <= (cmd_i.kind == KIND_ALLOC) ? S_ALLOC : S_SEARCH;
          end
        end
        S_ALLOC: begin
          if (alloc_fin) begin
            if (!empty_q) begin
              fc_q                <= fc_q - 1'b1;
              in_use_q[alloc_idx] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        S_SEARCH: begin
          if (search_end) begin
            if (found) begin
              in_use_q[hit_slot] <= 1'b0;
              if (fc_q != COUNT_W'(MAX_SLOTS)) begin
                written_q[fc_q[SLOT_IDX_W-1:0]] <= 1'b1;
                fc_q <= fc_q + 1'b1;
              end
            end
            state_q <= S_IDLE;
          end else if (!found && !last_chunk) begin
            ch_q  <= ch_q + 1'b1;
            acc_q <= acc_q + ADDR_W'(LANE_OFF_W'(size_q) << LANE_W);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= out_status_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.slot_address = out_addr_q;
  assign rsp_o.status       = out_status_q;

  // Checks
  `FSPA_ASSERT(fc_within_pool_a, fc_q <= pool_n, "free count exceeds pool size")
  `FSPA_ASSERT(hit_leaves_room_a, !(state_q == S_SEARCH && found) || fc_q < pool_n,
               "in-use slot found with a full free stack")
  `FSPA_ASSERT_NEXT(grant_pops_a, alloc_fin && !empty_q && !cfg_we_i,
                    fc_q == $past(fc_q) - 1'b1, "grant did not pop the free stack")

endmodule

`default_nettype wire

[hw/rtl/fixed_slot_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Pool of equal-size slots handed out from a LIFO free stack.
// ----------------------------------------------------------------------------
// Each request transaction either allocates a slot (returns base +
// index * slot_size, or status empty) or releases one by address (status
// done, or not in use for a null or unknown address). The front end queues
// up to two commands so requests keep flowing while the back end works.
// An allocate first does the registered free stack read, then forms the
// address. A release of a null address is answered directly; any other
// release searches the pool, comparing 16 slot addresses per cycle and
// stopping at the first in-use match. Any register write re-initializes
// the pool in the same cycle; no clearing pass follows reset or
// configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_pool_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fspa_req_if.sink                             req_i,
  fspa_rsp_if.source                           rsp_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fspa_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  // Accept and classify
  fspa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute
  fspa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
